// File: rtl/sdi_pkg.sv
package sdi_pkg;

   localparam int unsigned PhaseW = 4;
   localparam int unsigned RetryW = 17;
   localparam int unsigned LimitW = 16;
   localparam int unsigned DivW   = 8;
   localparam int unsigned WordW  = 32;
   localparam int unsigned RcaW   = 16;
   localparam int unsigned ClassW = 12;

   localparam logic [PhaseW-1:0] PH_IDLE      = 4'd0;
   localparam logic [PhaseW-1:0] PH_CMD0      = 4'd1;
   localparam logic [PhaseW-1:0] PH_CMD8      = 4'd2;
   localparam logic [PhaseW-1:0] PH_CMD55     = 4'd3;
   localparam logic [PhaseW-1:0] PH_ACMD41    = 4'd4;
   localparam logic [PhaseW-1:0] PH_CMD2      = 4'd5;
   localparam logic [PhaseW-1:0] PH_CMD3      = 4'd6;
   localparam logic [PhaseW-1:0] PH_CMD9      = 4'd7;
   localparam logic [PhaseW-1:0] PH_CMD7      = 4'd8;
   localparam logic [PhaseW-1:0] PH_CMD13     = 4'd9;
   localparam logic [PhaseW-1:0] PH_DONE      = 4'd10;
   localparam logic [PhaseW-1:0] PH_F_TIMEOUT = 4'd11;
   localparam logic [PhaseW-1:0] PH_F_CRC     = 4'd12;
   localparam logic [PhaseW-1:0] PH_F_VOLT    = 4'd13;

   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_RESP   = 2'd1;
   localparam logic [1:0] OP_DEINIT = 2'd2;

   localparam logic [1:0] RS_OK      = 2'd0;
   localparam logic [1:0] RS_TIMEOUT = 2'd1;
   localparam logic [1:0] RS_CRC     = 2'd2;

   localparam logic [2:0] ST_BUSY    = 3'd0;
   localparam logic [2:0] ST_OK      = 3'd1;
   localparam logic [2:0] ST_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_CRC     = 3'd3;
   localparam logic [2:0] ST_VOLT    = 3'd4;

   localparam logic [1:0] RK_NONE  = 2'd0;
   localparam logic [1:0] RK_SHORT = 2'd1;
   localparam logic [1:0] RK_LONG  = 2'd2;

   localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0] CMD_ALL_CID   = 6'd2;
   localparam logic [5:0] CMD_REL_ADDR  = 6'd3;
   localparam logic [5:0] CMD_SELECT    = 6'd7;
   localparam logic [5:0] CMD_IF_COND   = 6'd8;
   localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
   localparam logic [5:0] CMD_STATUS    = 6'd13;
   localparam logic [5:0] CMD_OP_COND   = 6'd41;
   localparam logic [5:0] CMD_APP       = 6'd55;

   localparam logic [WordW-1:0] IF_COND_ARG = 32'h0000_01AA;
   localparam logic [WordW-1:0] OP_COND_ARG = 32'hC110_0000;
   localparam logic [DivW-1:0]  SLOW_DIV_CODE = 8'd123;
   localparam logic [DivW-1:0]  MIN_DIV = 8'd2;
   localparam logic [3:0]       STATE_TRAN = 4'd4;

   localparam logic CSR_RETRY_LIMIT = 1'b0;
   localparam logic CSR_FAST_DIV    = 1'b1;

   typedef struct packed {
      logic              issue_cmd;
      logic [5:0]        cmd_index;
      logic [WordW-1:0]  cmd_arg;
      logic [1:0]        resp_kind;
      logic [DivW-1:0]   clock_div_code;
      logic [2:0]        status;
      logic              initialised;
      logic              card_v2;
      logic              high_capacity;
      logic [RcaW-1:0]   card_address;
      logic [ClassW-1:0] command_classes;
   } result_type;

endpackage

// File: rtl/sd_card_init_sequencer.sv
// SD card bring-up sequencer. Send op 0 to start (result asks for CMD0), then one op 1 item
// per command response; each result names the next command (index, argument, expected
// response kind) or none, plus the divider code, status and the card facts learned so far.
// Op 2 returns to idle. One item is accepted every clock cycle while rsp_stall does not back up
// the output; each result passes through one input register and one result register, waiting
// in the input register while an earlier result is held by rsp_stall, with the phase and card
// registers updated in the single step between them. Write retry_limit (index 0) and
// fast_divider (index 1) only while no item is in flight.
module sd_card_init_sequencer
   import sdi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [1:0]        req_resp_status,
   input  logic [WordW-1:0]  req_resp_word0,
   input  logic [WordW-1:0]  req_resp_word1,
   input  logic [WordW-1:0]  req_resp_word2,
   input  logic [WordW-1:0]  req_resp_word3,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_issue_cmd,
   output logic [5:0]        rsp_cmd_index,
   output logic [WordW-1:0]  rsp_cmd_arg,
   output logic [1:0]        rsp_resp_kind,
   output logic [DivW-1:0]   rsp_clock_div_code,
   output logic [2:0]        rsp_status,
   output logic              rsp_initialised,
   output logic              rsp_card_v2,
   output logic              rsp_high_capacity,
   output logic [RcaW-1:0]   rsp_card_address,
   output logic [ClassW-1:0] rsp_command_classes,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [LimitW-1:0] csr_data
);

   logic              in_valid_ff;
   logic [1:0]        op_ff;
   logic [1:0]        rs_ff;
   logic [WordW-1:0]  w0_ff;
   logic [WordW-1:0]  w1_ff;

   logic              out_valid_ff;
   result_type        res_ff;
   result_type        res_in;

   logic [LimitW-1:0] limit_ff;
   logic [DivW-1:0]   fdiv_ff;

   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [RetryW-1:0] retry_ff, retry_in;
   logic              v2_ff, v2_in;
   logic              hc_ff, hc_in;
   logic [RcaW-1:0]   rca_ff, rca_in;
   logic [ClassW-1:0] class_ff, class_in;
   logic              ready_ff, ready_in;

   logic              fire;
   logic              in_free;
   logic [RetryW-1:0] retry_inc;
   logic              retry_over;
   logic [WordW-1:0]  addr_arg;
   logic              fail_to;

   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign in_free   = !in_valid_ff || fire;
   assign req_stall = !in_free;
   assign csr_ready = 1'b1;

   assign retry_inc  = retry_ff + RetryW'(1);
   assign retry_over = retry_inc > {1'b0, limit_ff};
   assign addr_arg   = {rca_ff, 16'h0000};
   assign fail_to    = (rs_ff == RS_TIMEOUT);

   always_comb begin
      phase_in = phase_ff;
      retry_in = retry_ff;
      v2_in    = v2_ff;
      hc_in    = hc_ff;
      rca_in   = rca_ff;
      class_in = class_ff;
      ready_in = ready_ff;
      res_in   = '0;

      unique case (op_ff)
         OP_START: begin
            v2_in    = 1'b0;
            hc_in    = 1'b0;
            ready_in = 1'b0;
            retry_in = '0;
            phase_in = PH_CMD0;
            res_in.issue_cmd = 1'b1;
            res_in.cmd_index = CMD_GO_IDLE;
            res_in.resp_kind = RK_NONE;
         end
         OP_RESP: begin
            unique case (phase_ff)
               PH_CMD0: begin
                  if (fail_to) begin
                     phase_in = PH_F_TIMEOUT;
                  end else begin
                     phase_in = PH_CMD8;
                     res_in.issue_cmd = 1'b1;
                     res_in.cmd_index = CMD_IF_COND;
                     res_in.cmd_arg   = IF_COND_ARG;
                     res_in.resp_kind = RK_SHORT;
                  end
               end
               PH_CMD8: begin
                  if (rs_ff == RS_OK && !w0_ff[8]) begin
                     phase_in = PH_F_VOLT;
                  end else begin
                     if (rs_ff == RS_OK) begin
                        v2_in = 1'b1;
                     end
                     phase_in = PH_CMD55;
                     res_in.issue_cmd = 1'b1;
                     res_in.cmd_index = CMD_APP;
                     res_in.resp_kind = RK_SHORT;
                  end
               end
               PH_CMD55: begin
                  if (rs_ff != RS_OK) begin
                     phase_in = fail_to ? PH_F_TIMEOUT : PH_F_CRC;
                  end else begin
                     phase_in = PH_ACMD41;
                     res_in.issue_cmd = 1'b1;
                     res_in.cmd_index = CMD_OP_COND;
                     res_in.cmd_arg   = OP_COND_ARG;
                     res_in.resp_kind = RK_SHORT;
                  end
               end
               PH_ACMD41: begin
                  if (!fail_to) begin
                     hc_in = w0_ff[30];
                  end
                  retry_in = retry_inc;
                  if (retry_over) begin
                     phase_in = PH_F_TIMEOUT;
                  end else if (!fail_to && w0_ff[31]) begin
                     phase_in = PH_CMD2;
                     res_in.issue_cmd = 1'b1;
                     res_in.cmd_index = CMD_ALL_CID;
                     res_in.resp_kind = RK_LONG;
                  end else begin
                     phase_in = PH_CMD55;
                     res_in.issue_cmd = 1'b1;
                     res_in.cmd_index = CMD_APP;
                     res_in.resp_kind = RK_SHORT;
                  end
               end
               PH_CMD2: begin
                  if (rs_ff != RS_OK) begin
                     phase_in = fail_to ? PH_F_TIMEOUT : PH_F_CRC;
                  end else begin
                     phase_in = PH_CMD3;
                     res_in.issue_cmd = 1'b1;
                     res_in.cmd_index = CMD_REL_ADDR;
                     res_in.resp_kind = RK_SHORT;
                  end
               end
               PH_CMD3: begin
                  if (rs_ff != RS_OK) begin
                     phase_in = fail_to ? PH_F_TIMEOUT : PH_F_CRC;
                  end else begin
                     rca_in   = w0_ff[31:16];
                     phase_in = PH_CMD9;
                     res_in.issue_cmd = 1'b1;
                     res_in.cmd_index = CMD_SEND_CSD;
                     res_in.cmd_arg   = {w0_ff[31:16], 16'h0000};
                     res_in.resp_kind = RK_LONG;
                  end
               end
               PH_CMD9: begin
                  if (rs_ff != RS_OK) begin
                     phase_in = fail_to ? PH_F_TIMEOUT : PH_F_CRC;
                  end else begin
                     class_in = w1_ff[31:20];
                     phase_in = PH_CMD7;
                     res_in.issue_cmd = 1'b1;
                     res_in.cmd_index = CMD_SELECT;
                     res_in.cmd_arg   = addr_arg;
                     res_in.resp_kind = RK_SHORT;
                  end
               end
               PH_CMD7: begin
                  if (rs_ff != RS_OK) begin
                     phase_in = fail_to ? PH_F_TIMEOUT : PH_F_CRC;
                  end else begin
                     retry_in = '0;
                     phase_in = PH_CMD13;
                     res_in.issue_cmd = 1'b1;
                     res_in.cmd_index = CMD_STATUS;
                     res_in.cmd_arg   = addr_arg;
                     res_in.resp_kind = RK_SHORT;
                  end
               end
               PH_CMD13: begin
                  if (rs_ff != RS_OK) begin
                     phase_in = fail_to ? PH_F_TIMEOUT : PH_F_CRC;
                  end else if (w0_ff[12:9] == STATE_TRAN) begin
                     ready_in = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     retry_in = retry_inc;
                     if (retry_over) begin
                        phase_in = PH_F_TIMEOUT;
                     end else begin
                        res_in.issue_cmd = 1'b1;
                        res_in.cmd_index = CMD_STATUS;
                        res_in.cmd_arg   = addr_arg;
                        res_in.resp_kind = RK_SHORT;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         OP_DEINIT: begin
            ready_in = 1'b0;
            phase_in = PH_IDLE;
         end
         default: begin
         end
      endcase

      if (ready_in) begin
         res_in.clock_div_code = (fdiv_ff < MIN_DIV) ? '0 : fdiv_ff - MIN_DIV;
      end else begin
         res_in.clock_div_code = SLOW_DIV_CODE;
      end

      unique case (phase_in)
         PH_DONE:      res_in.status = ST_OK;
         PH_F_TIMEOUT: res_in.status = ST_TIMEOUT;
         PH_F_CRC:     res_in.status = ST_CRC;
         PH_F_VOLT:    res_in.status = ST_VOLT;
         default:      res_in.status = ST_BUSY;
      endcase

      res_in.initialised     = ready_in;
      res_in.card_v2         = v2_in;
      res_in.high_capacity   = hc_in;
      res_in.card_address    = rca_in;
      res_in.command_classes = class_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= 16'hFFFF;
         fdiv_ff      <= MIN_DIV;
         phase_ff     <= PH_IDLE;
         retry_ff     <= '0;
         v2_ff        <= 1'b0;
         hc_ff        <= 1'b0;
         rca_ff       <= '0;
         class_ff     <= '0;
         ready_ff     <= 1'b0;
      end else begin
         if (in_free) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            retry_ff     <= retry_in;
            v2_ff        <= v2_in;
            hc_ff        <= hc_in;
            rca_ff       <= rca_in;
            class_ff     <= class_in;
            ready_ff     <= ready_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RETRY_LIMIT) begin
               limit_ff <= csr_data;
            end else begin
               fdiv_ff <= csr_data[DivW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         op_ff <= req_op;
         rs_ff <= req_resp_status;
         w0_ff <= req_resp_word0;
         w1_ff <= req_resp_word1;
      end
      if (fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_issue_cmd       = res_ff.issue_cmd;
   assign rsp_cmd_index       = res_ff.cmd_index;
   assign rsp_cmd_arg         = res_ff.cmd_arg;
   assign rsp_resp_kind       = res_ff.resp_kind;
   assign rsp_clock_div_code  = res_ff.clock_div_code;
   assign rsp_status          = res_ff.status;
   assign rsp_initialised     = res_ff.initialised;
   assign rsp_card_v2         = res_ff.card_v2;
   assign rsp_high_capacity   = res_ff.high_capacity;
   assign rsp_card_address    = res_ff.card_address;
   assign rsp_command_classes = res_ff.command_classes;

   logic unused_words;
   assign unused_words = ^{req_resp_word2, req_resp_word3, w1_ff[19:0]};

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import sdi_pkg::*;

   localparam int unsigned CycleLimit = 1_000_000;
   localparam int unsigned SegItems = 320;

   typedef struct packed {
      logic [1:0]       op;
      logic [1:0]       rs;
      logic [WordW-1:0] w0;
      logic [WordW-1:0] w1;
      logic [WordW-1:0] w2;
      logic [WordW-1:0] w3;
   } request_type;

   class bringup_scoreboard;
      logic [LimitW-1:0] retry_limit;
      logic [DivW-1:0]   fast_div;
      logic [PhaseW-1:0] phase;
      logic [RetryW-1:0] retries;
      logic              v2, hc, ready, fast_clk;
      logic [RcaW-1:0]   rca;
      logic [WordW-1:0]  cid [4];
      logic [WordW-1:0]  csd [4];
      logic [ClassW-1:0] classes;
      result_type        owed_results [$];
      int                errors;

      function new();
         retry_limit = 16'hFFFF;
         fast_div = MIN_DIV;
         phase = PH_IDLE;
         retries = '0;
         {v2, hc, ready, fast_clk} = '0;
         rca = '0;
         classes = '0;
         for (int i = 0; i < 4; i++) begin
            cid[i] = '0;
            csd[i] = '0;
         end
         errors = 0;
      endfunction

      function void report(string msg);
         if (errors < 100) begin
            $display("tb: mismatch at %0t: %s", $time, msg);
         end
         errors++;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function void set_reg(logic idx, logic [LimitW-1:0] data);
         if (idx == CSR_RETRY_LIMIT) begin
            retry_limit = data;
         end else begin
            fast_div = data[DivW-1:0];
         end
      endfunction

      function logic [PhaseW-1:0] failed_phase(logic [1:0] rs);
         return (rs == RS_TIMEOUT) ? PH_F_TIMEOUT : PH_F_CRC;
      endfunction

      function void set_cmd(inout result_type res, input logic [5:0] idx,
                            input logic [WordW-1:0] arg, input logic [1:0] kind);
         res.issue_cmd = 1'b1;
         res.cmd_index = idx;
         res.cmd_arg = arg;
         res.resp_kind = kind;
      endfunction

      function void take_request(request_type r);
         result_type       res;
         logic [WordW-1:0] sel_arg;
         logic [DivW-1:0]  div;
         logic             card_ready;
         res = '0;
         sel_arg = {rca, 16'h0000};
         case (r.op)
            OP_START: begin
               {v2, hc, ready, fast_clk} = '0;
               retries = '0;
               phase = PH_CMD0;
               set_cmd(res, CMD_GO_IDLE, '0, RK_NONE);
            end
            OP_DEINIT: begin
               ready = 1'b0;
               fast_clk = 1'b0;
               phase = PH_IDLE;
            end
            OP_RESP: begin
               case (phase)
                  PH_CMD0: begin
                     if (r.rs == RS_TIMEOUT) begin
                        phase = PH_F_TIMEOUT;
                     end else begin
                        phase = PH_CMD8;
                        set_cmd(res, CMD_IF_COND, IF_COND_ARG, RK_SHORT);
                     end
                  end
                  PH_CMD8: begin
                     if (r.rs == RS_OK && !r.w0[8]) begin
                        phase = PH_F_VOLT;
                     end else begin
                        if (r.rs == RS_OK) v2 = 1'b1;
                        phase = PH_CMD55;
                        set_cmd(res, CMD_APP, '0, RK_SHORT);
                     end
                  end
                  PH_CMD55: begin
                     if (r.rs != RS_OK) begin
                        phase = failed_phase(r.rs);
                     end else begin
                        phase = PH_ACMD41;
                        set_cmd(res, CMD_OP_COND, OP_COND_ARG, RK_SHORT);
                     end
                  end
                  PH_ACMD41: begin
                     card_ready = 1'b0;
                     if (r.rs != RS_TIMEOUT) begin
                        card_ready = r.w0[31];
                        hc = r.w0[30];
                     end
                     retries = retries + 1'b1;
                     if (retries > retry_limit) begin
                        phase = PH_F_TIMEOUT;
                     end else if (card_ready) begin
                        phase = PH_CMD2;
                        set_cmd(res, CMD_ALL_CID, '0, RK_LONG);
                     end else begin
                        phase = PH_CMD55;
                        set_cmd(res, CMD_APP, '0, RK_SHORT);
                     end
                  end
                  PH_CMD2: begin
                     if (r.rs != RS_OK) begin
                        phase = failed_phase(r.rs);
                     end else begin
                        cid = '{r.w0, r.w1, r.w2, r.w3};
                        phase = PH_CMD3;
                        set_cmd(res, CMD_REL_ADDR, '0, RK_SHORT);
                     end
                  end
                  PH_CMD3: begin
                     if (r.rs != RS_OK) begin
                        phase = failed_phase(r.rs);
                     end else begin
                        rca = r.w0[31:16];
                        phase = PH_CMD9;
                        set_cmd(res, CMD_SEND_CSD, {rca, 16'h0000}, RK_LONG);
                     end
                  end
                  PH_CMD9: begin
                     if (r.rs != RS_OK) begin
                        phase = failed_phase(r.rs);
                     end else begin
                        csd = '{r.w0, r.w1, r.w2, r.w3};
                        classes = r.w1[31:20];
                        phase = PH_CMD7;
                        set_cmd(res, CMD_SELECT, sel_arg, RK_SHORT);
                     end
                  end
                  PH_CMD7: begin
                     if (r.rs != RS_OK) begin
                        phase = failed_phase(r.rs);
                     end else begin
                        retries = '0;
                        phase = PH_CMD13;
                        set_cmd(res, CMD_STATUS, sel_arg, RK_SHORT);
                     end
                  end
                  PH_CMD13: begin
                     if (r.rs != RS_OK) begin
                        phase = failed_phase(r.rs);
                     end else if (r.w0[12:9] == STATE_TRAN) begin
                        fast_clk = 1'b1;
                        ready = 1'b1;
                        phase = PH_DONE;
                     end else begin
                        retries = retries + 1'b1;
                        if (retries > retry_limit) begin
                           phase = PH_F_TIMEOUT;
                        end else begin
                           set_cmd(res, CMD_STATUS, sel_arg, RK_SHORT);
                        end
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase

         div = (fast_div < MIN_DIV) ? MIN_DIV : fast_div;
         res.clock_div_code = fast_clk ? div - MIN_DIV : SLOW_DIV_CODE;
         case (phase)
            PH_DONE:      res.status = ST_OK;
            PH_F_TIMEOUT: res.status = ST_TIMEOUT;
            PH_F_CRC:     res.status = ST_CRC;
            PH_F_VOLT:    res.status = ST_VOLT;
            default:      res.status = ST_BUSY;
         endcase
         res.initialised = ready;
         res.card_v2 = v2;
         res.high_capacity = hc;
         res.card_address = rca;
         res.command_classes = classes;
         owed_results.push_back(res);
      endfunction

      function void cmp(string name, logic [WordW-1:0] got, logic [WordW-1:0] want);
         if (got !== want) begin
            report($sformatf("%s got %h expected %h", name, got, want));
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed_results.size() == 0) begin
            report("result with none outstanding");
            return;
         end
         want = owed_results.pop_front();
         cmp("issue_cmd", got.issue_cmd, want.issue_cmd);
         cmp("cmd_index", got.cmd_index, want.cmd_index);
         cmp("cmd_arg", got.cmd_arg, want.cmd_arg);
         cmp("resp_kind", got.resp_kind, want.resp_kind);
         cmp("clock_div_code", got.clock_div_code, want.clock_div_code);
         cmp("status", got.status, want.status);
         cmp("initialised", got.initialised, want.initialised);
         cmp("card_v2", got.card_v2, want.card_v2);
         cmp("high_capacity", got.high_capacity, want.high_capacity);
         cmp("card_address", got.card_address, want.card_address);
         cmp("command_classes", got.command_classes, want.command_classes);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_op;
   logic [1:0]        req_resp_status;
   logic [WordW-1:0]  req_resp_word0;
   logic [WordW-1:0]  req_resp_word1;
   logic [WordW-1:0]  req_resp_word2;
   logic [WordW-1:0]  req_resp_word3;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_issue_cmd;
   logic [5:0]        rsp_cmd_index;
   logic [WordW-1:0]  rsp_cmd_arg;
   logic [1:0]        rsp_resp_kind;
   logic [DivW-1:0]   rsp_clock_div_code;
   logic [2:0]        rsp_status;
   logic              rsp_initialised;
   logic              rsp_card_v2;
   logic              rsp_high_capacity;
   logic [RcaW-1:0]   rsp_card_address;
   logic [ClassW-1:0] rsp_command_classes;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_index;
   logic [LimitW-1:0] csr_data;

   bringup_scoreboard sb = new();
   bit quiet = 1'b0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;

   sd_card_init_sequencer uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   task automatic send(input request_type r);
      req_valid <= 1'b1;
      req_op <= r.op;
      req_resp_status <= r.rs;
      req_resp_word0 <= r.w0;
      req_resp_word1 <= r.w1;
      req_resp_word2 <= r.w2;
      req_resp_word3 <= r.w3;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_request(r);
   endtask

   task automatic step(input logic [1:0] op, input logic [1:0] rs,
                       input logic [WordW-1:0] w0 = '0, input logic [WordW-1:0] w1 = '0,
                       input logic [WordW-1:0] w2 = '0, input logic [WordW-1:0] w3 = '0);
      send({op, rs, w0, w1, w2, w3});
   endtask

   task automatic idle(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [LimitW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_reg(idx, data);
   endtask

   task automatic configure(input logic [LimitW-1:0] limit, input logic [LimitW-1:0] div);
      write_reg(CSR_RETRY_LIMIT, limit);
      write_reg(CSR_FAST_DIV, div);
      csr_valid <= 1'b0;
   endtask

   function automatic request_type make_item();
      request_type r;
      logic        bad;
      r.op = OP_RESP;
      r.rs = RS_OK;
      r.w0 = $urandom;
      r.w1 = $urandom;
      r.w2 = $urandom;
      r.w3 = $urandom;
      bad = ($urandom_range(0, 24) == 0);
      if (bad) r.rs = 2'($urandom_range(1, 3));
      case (sb.phase)
         PH_IDLE, PH_DONE, PH_F_TIMEOUT, PH_F_CRC, PH_F_VOLT:
            r.op = ($urandom_range(0, 9) == 0) ? OP_DEINIT : OP_START;
         PH_CMD8: if (!bad) r.w0[8] = ($urandom_range(0, 29) != 0);
         PH_ACMD41: r.w0[31] = ($urandom_range(0, 2) == 0);
         PH_CMD13: if ($urandom_range(0, 2) == 0) r.w0[12:9] = STATE_TRAN;
         default: ;
      endcase
      // inject noise: any op, any status
      if ($urandom_range(0, 19) == 0) begin
         r.op = 2'($urandom_range(0, 3));
         r.rs = 2'($urandom_range(0, 3));
      end
      return r;
   endfunction

   // result side: random stall bursts plus one long hold-off
   initial begin
      int         burst;
      int         hold;
      result_type got;
      burst = 0;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = {rsp_issue_cmd, rsp_cmd_index, rsp_cmd_arg, rsp_resp_kind,
                   rsp_clock_div_code, rsp_status, rsp_initialised, rsp_card_v2,
                   rsp_high_capacity, rsp_card_address, rsp_command_classes};
            sb.check_result(got);
         end
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            burst = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [LimitW-1:0] limits [6];
      logic [LimitW-1:0] divs [6];
      bit                calm;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_START;
      req_resp_status <= RS_OK;
      req_resp_word0 <= '0;
      req_resp_word1 <= '0;
      req_resp_word2 <= '0;
      req_resp_word3 <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_RETRY_LIMIT;
      csr_data <= '0;
      limits = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0003, 16'($urandom), 16'hFFFF};
      divs = '{16'h00FF, 16'h0000, 16'hAB01, 16'h0002, 16'($urandom), 16'h0055};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full bring-up at reset settings
      step(OP_START, RS_OK, '1, '1, '1, '1);
      step(OP_RESP, RS_CRC);
      step(OP_RESP, RS_OK, 32'h0000_01AA);
      step(OP_RESP, RS_OK);
      step(OP_RESP, RS_CRC, 32'h4000_0000);
      step(OP_RESP, RS_OK);
      step(OP_RESP, 2'd3, 32'hC0FF_FF00);
      step(OP_RESP, RS_OK, '1, '1, '1, '1);
      step(OP_RESP, RS_OK, 32'hFFFF_0000);
      step(OP_RESP, RS_OK, '0, 32'hFFF0_0000, '1, '1);
      step(OP_RESP, RS_OK);
      step(OP_RESP, RS_OK, 32'h0000_0A00);
      step(OP_RESP, RS_OK, 32'h0000_0800);
      // stray response, unknown op, deinit
      step(OP_RESP, RS_OK, '1);
      step(2'd3, 2'd3, '1, '1, '1, '1);
      step(OP_DEINIT, RS_OK);
      // timeout on reset command
      step(OP_START, RS_OK);
      step(OP_RESP, RS_TIMEOUT);
      // restart while busy, then bad voltage
      step(OP_START, RS_OK);
      step(OP_RESP, RS_OK);
      step(OP_START, RS_OK);
      step(OP_RESP, RS_OK);
      step(OP_RESP, RS_OK, 32'hFFFF_FEFF);
      // version 1 card, then crc failure on app command
      step(OP_START, RS_OK);
      step(OP_RESP, RS_OK);
      step(OP_RESP, RS_TIMEOUT);
      step(OP_RESP, RS_CRC);

      for (int seg = 0; seg < 6; seg++) begin
         drain();
         configure(limits[seg], divs[seg]);
         if (seg == 5) quiet = 1'b1;
         if (seg == 2) hold_req = 1'b1;
         calm = 1'b0;
         for (int n = 0; n < SegItems; n++) begin
            if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            send(make_item());
            if (!quiet && !calm && $urandom_range(0, 9) == 0) idle($urandom_range(1, 19));
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) sb.report("results never arrived");
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
